[hw/rtl/cicc_pkg.sv]
// Package with the constants, types and CRC function of the image header checker.
package cicc_pkg;

  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [31:0] IMAGE_MAGIC   = 32'h0043584D;
  localparam logic [7:0]  IMAGE_VERSION = 8'h01;
  localparam logic [15:0] HEADER_BYTES  = 16'd15;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;

  localparam logic [15:0] POS_MAGIC_END  = 16'd3;
  localparam logic [15:0] POS_VERSION    = 16'd4;
  localparam logic [15:0] POS_SCHEMA_END = 16'd8;
  localparam logic [15:0] POS_LEN_LO     = 16'd9;
  localparam logic [15:0] POS_LEN_HI     = 16'd10;
  localparam logic [15:0] POS_HCRC_LO    = 16'd11;
  localparam logic [15:0] POS_HCRC_HI    = 16'd12;
  localparam logic [15:0] POS_PCRC_LO    = 16'd13;
  localparam logic [15:0] POS_PCRC_HI    = 16'd14;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_MAGIC   = 2'd1,
    ST_BAD_VERSION = 2'd2,
    ST_BAD_CRC     = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        failed_check;
    logic [15:0] computed_crc;
    logic [15:0] payload_length;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/cicc_ifs.sv]
// Interfaces for the input, result and configuration channels of the checker.
interface cicc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface cicc_out_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic                  failed_check;
  logic [15:0]           computed_crc;
  logic [15:0]           payload_length;
  modport source (output valid, output status, output failed_check, output computed_crc,
                  output payload_length, input ready);
  modport sink (input valid, input status, input failed_check, input computed_crc,
                input payload_length, output ready);
endinterface

interface cicc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] expected_schema;
  modport source (output valid, output expected_schema, input ready);
  modport sink (input valid, input expected_schema, output ready);
endinterface

[hw/rtl/cicc_parser.sv]
// Header parser, CRC engine and verdict logic for one image byte per cycle while step is high.
module cicc_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 first_byte,
  input  logic [31:0]          expected_schema,
  output logic                 res_valid,
  output cicc_pkg::result_t    res
);

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [15:0] total_r, total_nxt;
  logic [15:0] hcrc_r, hcrc_nxt;
  logic [15:0] pcrc_r, pcrc_nxt;
  logic        verdict_r;

  logic [15:0] pos_cur, crc_cur, total_cur, hcrc_cur, pcrc_cur;
  logic [31:0] shift_cur;
  logic        idle;
  logic [15:0] crc_upd;
  logic        hit;
  cicc_pkg::status_t st;
  logic        fc;
  logic [15:0] ccrc;

  always_comb begin
    pos_cur   = first_byte ? 16'd0 : pos_r;
    crc_cur   = first_byte ? cicc_pkg::CRC_INIT : crc_r;
    shift_cur = first_byte ? 32'd0 : shift_r;
    total_cur = first_byte ? 16'd0 : total_r;
    hcrc_cur  = first_byte ? 16'd0 : hcrc_r;
    pcrc_cur  = first_byte ? 16'd0 : pcrc_r;
    idle      = first_byte ? 1'b0 : verdict_r;

    shift_nxt = {data_byte, shift_cur[31:8]};
    crc_upd   = cicc_pkg::crc_byte(crc_cur, data_byte);
    crc_nxt   = (pos_cur <= cicc_pkg::POS_LEN_HI) ? crc_upd : crc_cur;
    total_nxt = total_cur;
    hcrc_nxt  = hcrc_cur;
    pcrc_nxt  = pcrc_cur;
    hit       = 1'b0;
    st        = cicc_pkg::ST_OK;
    fc        = 1'b0;
    ccrc      = 16'd0;

    case (pos_cur)
      cicc_pkg::POS_MAGIC_END: begin
        if (shift_nxt != cicc_pkg::IMAGE_MAGIC) begin
          hit = 1'b1;
          st  = cicc_pkg::ST_BAD_MAGIC;
        end
      end
      cicc_pkg::POS_VERSION: begin
        if (data_byte != cicc_pkg::IMAGE_VERSION) begin
          hit = 1'b1;
          st  = cicc_pkg::ST_BAD_VERSION;
        end
      end
      cicc_pkg::POS_SCHEMA_END: begin
        if (shift_nxt != expected_schema) begin
          hit = 1'b1;
          st  = cicc_pkg::ST_BAD_VERSION;
        end
      end
      cicc_pkg::POS_LEN_LO: total_nxt = {8'h00, data_byte};
      cicc_pkg::POS_LEN_HI: total_nxt = {data_byte, total_cur[7:0]};
      cicc_pkg::POS_HCRC_LO: hcrc_nxt = {8'h00, data_byte};
      cicc_pkg::POS_HCRC_HI: begin
        hcrc_nxt = {data_byte, hcrc_cur[7:0]};
        if (hcrc_nxt != crc_cur) begin
          hit  = 1'b1;
          st   = cicc_pkg::ST_BAD_CRC;
          ccrc = crc_cur;
        end else if (total_cur < cicc_pkg::HEADER_BYTES) begin
          hit = 1'b1;
          st  = cicc_pkg::ST_BAD_MAGIC;
        end
        crc_nxt = cicc_pkg::CRC_INIT;
      end
      cicc_pkg::POS_PCRC_LO: pcrc_nxt = {8'h00, data_byte};
      cicc_pkg::POS_PCRC_HI: pcrc_nxt = {data_byte, pcrc_cur[7:0]};
      default: begin
        if (pos_cur >= cicc_pkg::HEADER_BYTES) begin
          crc_nxt = crc_upd;
        end
      end
    endcase

    if (!hit && pos_cur >= cicc_pkg::POS_PCRC_HI &&
        ({1'b0, pos_cur} + 17'd1) == {1'b0, total_nxt}) begin
      hit  = 1'b1;
      ccrc = crc_nxt;
      if (crc_nxt == pcrc_nxt) begin
        st = cicc_pkg::ST_OK;
      end else begin
        st = cicc_pkg::ST_BAD_CRC;
        fc = 1'b1;
      end
    end

    pos_nxt = (pos_cur == cicc_pkg::POS_MAX) ? pos_cur : pos_cur + 16'd1;

    res_valid          = step && !idle && hit;
    res.status         = st;
    res.failed_check   = fc;
    res.computed_crc   = ccrc;
    res.payload_length = (pos_cur >= cicc_pkg::POS_LEN_HI &&
                          total_nxt >= cicc_pkg::HEADER_BYTES) ?
                         total_nxt - cicc_pkg::HEADER_BYTES : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 16'd0;
      crc_r     <= cicc_pkg::CRC_INIT;
      shift_r   <= 32'd0;
      total_r   <= 16'd0;
      hcrc_r    <= 16'd0;
      pcrc_r    <= 16'd0;
      verdict_r <= 1'b1;
    end else if (step && !idle) begin
      pos_r     <= pos_nxt;
      crc_r     <= crc_nxt;
      shift_r   <= shift_nxt;
      total_r   <= total_nxt;
      hcrc_r    <= hcrc_nxt;
      pcrc_r    <= pcrc_nxt;
      verdict_r <= hit;
    end
  end

endmodule

[hw/rtl/config_image_header_crc_checker_core.sv]
// Top level of the configuration image header and CRC checker.
// The block takes one byte of a stored configuration image per item on in_if.
// An item with first_byte set starts a new image; bytes that arrive after a
// verdict and before the next first byte are dropped without a result.
// The 15-byte header is checked for magic, version, schema id, header CRC and
// total length, and a CRC-16-CCITT runs over the payload that follows.
// At most one result item per image leaves on out_if, at the first failure or
// after the last byte of the image.
// The expected schema is written through cfg_if, which is always ready; write
// it only while no image is in flight.
// An accepted item is held in an input register, and its result is loaded into
// the output register when the parser steps on that byte, which waits while a
// result is pending and unread. The byte-wide CRC update sits between these two
// registers; the block takes one byte in every cycle unless the receiver stalls.
// When the receiver stalls, the pending result stays put and the input
// register keeps one more byte before in_if.ready drops.
// A synchronous reset empties both registers, clears the schema to zero and
// leaves the parser idle until the next first byte.
module config_image_header_crc_checker_core (
  input  logic        clk,
  input  logic        rst_n,
  cicc_in_if.sink     in_if,
  cicc_out_if.source  out_if,
  cicc_cfg_if.sink    cfg_if
);

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              in_first_r;
  logic              out_valid_r;
  cicc_pkg::result_t out_data_r;
  logic [31:0]       schema_r;
  logic              advance;
  logic              res_valid;
  cicc_pkg::result_t res;

  assign advance      = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !in_valid_r || advance;
  assign cfg_if.ready = 1'b1;

  cicc_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (advance),
    .data_byte       (in_byte_r),
    .first_byte      (in_first_r),
    .expected_schema (schema_r),
    .res_valid       (res_valid),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      schema_r    <= 32'd0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_if.valid) begin
        schema_r <= cfg_if.expected_schema;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_r  <= in_if.data_byte;
      in_first_r <= in_if.first_byte;
    end
    if (advance && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_data_r.status;
  assign out_if.failed_check   = out_data_r.failed_check;
  assign out_if.computed_crc   = out_data_r.computed_crc;
  assign out_if.payload_length = out_data_r.payload_length;

endmodule
